/* rtl/pmm_pkg.sv */
// ----------------------------------------------------------------------------
// pmm_pkg
// Shared types and codes of the paged memory manager.
// ----------------------------------------------------------------------------
package pmm_pkg;

    localparam int unsigned AGE_W   = 16;
    localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_ALLOC  = 3'd0,
        K_FREE   = 3'd1,
        K_ACCESS = 3'd2,
        K_SAVE   = 3'd3,
        K_LOAD   = 3'd4
    } t_kind;

    typedef struct packed {
        t_op         opcode;
        logic [6:0]  page_count;
        logic [5:0]  start_page;
        logic [17:0] virt_address;
        logic [7:0]  write_data;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic        ok;
        logic [5:0]  page_index;
        logic [15:0] mem_address;
        logic [17:0] disk_address;
        logic        is_write;
        logic [7:0]  data_out;
        logic        last;
    } t_out_beat;

endpackage

/* rtl/pmm_ram.sv */
// ----------------------------------------------------------------------------
// pmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pmm_out_stage.sv */
// ----------------------------------------------------------------------------
// pmm_out_stage
// Result output register; takes a new beat when empty or when the held one leaves.
// ----------------------------------------------------------------------------
module pmm_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pmm_pkg::t_out_beat i_beat,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output pmm_pkg::t_out_beat o_beat
);

    logic               r_valid;
    pmm_pkg::t_out_beat r_beat;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_ready) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (i_push && o_ready) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* rtl/paged_memory_manager.sv */
// ----------------------------------------------------------------------------
// paged_memory_manager
// Demand-paged store with first-fit allocation and aging replacement.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  input   | in  | i_in_valid / o_in_stall    | i_in_beat  (pmm_pkg::t_in_beat)
//  result  | out | o_out_valid / i_out_stall  | o_out_beat (pmm_pkg::t_out_beat)
//
//  Flow: one item at a time; every table entry visit is a read state that
//    puts out the address, then a check state on the registered RAM data.
//    Allocate scans the frames, the pages, then the frames again; free visits
//    each page; an access walks the memory frames, a miss first seeks free ones.
//  Reset: a clearing pass over max(VIRT_PAGES, TOTAL_FRAMES) entries zeroes both
//    RAMs; o_in_stall stays high meanwhile.
//  Stalls: results sit in an output register; the sequencer only waits when
//    a new beat is ready and that register is still held.
// ----------------------------------------------------------------------------
module paged_memory_manager #(
    parameter int unsigned PAGE_BYTES   = 4096,
    parameter int unsigned VIRT_PAGES   = 64,
    parameter int unsigned TOTAL_FRAMES = 64,
    parameter int unsigned MEM_FRAMES   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pmm_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pmm_pkg::t_out_beat o_out_beat
);

    // widths
    localparam int unsigned OFFW  = $clog2(PAGE_BYTES);
    localparam int unsigned PW    = $clog2(VIRT_PAGES);
    localparam int unsigned FW    = $clog2(TOTAL_FRAMES);
    localparam int unsigned ML    = (MEM_FRAMES < TOTAL_FRAMES) ? MEM_FRAMES : TOTAL_FRAMES;
    localparam int unsigned MAXVT = (VIRT_PAGES > TOTAL_FRAMES) ? VIRT_PAGES : TOTAL_FRAMES;
    localparam int unsigned CW    = $clog2(MAXVT) + 1;
    localparam int unsigned IW    = (PW + 1 > 8) ? PW + 1 : 8;
    localparam int unsigned AW    = pmm_pkg::AGE_W;
    localparam int unsigned PGW   = FW + 1;       // {in_use, frame}
    localparam int unsigned FRW   = AW + PW;      // {age, owner}

    typedef enum logic [20:0] {
        S_CLR     = 21'h000001,
        S_IDLE    = 21'h000002,
        S_CNT_RD  = 21'h000004,
        S_CNT_CK  = 21'h000008,
        S_FIT_RD  = 21'h000010,
        S_FIT_CK  = 21'h000020,
        S_ASG_RD  = 21'h000040,
        S_ASG_CK  = 21'h000080,
        S_FREE_RD = 21'h000100,
        S_FREE_CK = 21'h000200,
        S_X_RD    = 21'h000400,
        S_X_CK    = 21'h000800,
        S_M_RD    = 21'h001000,
        S_M_CK    = 21'h002000,
        S_D_RD    = 21'h004000,
        S_D_CK    = 21'h008000,
        S_SAVE    = 21'h010000,
        S_LOAD    = 21'h020000,
        S_G_RD    = 21'h040000,
        S_G_CK    = 21'h080000,
        S_REPLY   = 21'h100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;       // scan index
    logic [CW-1:0]      r_cnt, n_cnt;       // free frame count
    logic [7:0]         r_run, n_run;       // free page run length
    logic [6:0]         r_rem, n_rem;       // pages left
    logic [PW-1:0]      r_pg, n_pg;         // page being backed
    logic [PW-1:0]      r_start, n_start;
    logic [IW-1:0]      r_i, n_i;           // free walk page
    logic               r_ok, n_ok;
    logic [6:0]         r_n, n_n;
    logic [PW-1:0]      r_vp, n_vp;
    logic [OFFW-1:0]    r_off, n_off;
    logic               r_wr, n_wr;
    logic [7:0]         r_wd, n_wd;
    logic [FW-1:0]      r_f, n_f;           // frame finally used
    logic [FW-1:0]      r_d, n_d;           // disk frame of the page
    logic [FW-1:0]      r_vic, n_vic;
    logic [AW-1:0]      r_vage, n_vage;
    logic [PW-1:0]      r_vown, n_vown;
    logic [FW-1:0]      r_spare, n_spare;
    pmm_pkg::t_out_beat r_res, n_res;

    // RAM ports
    logic            pg_we, fr_we;
    logic [PW-1:0]   pg_waddr, pg_raddr;
    logic [FW-1:0]   fr_waddr, fr_raddr;
    logic [PGW-1:0]  pg_wdata, pg_rdata;
    logic [FRW-1:0]  fr_wdata, fr_rdata;

    logic               push, ofree;
    pmm_pkg::t_out_beat beat;

    logic            pg_use;
    logic [FW-1:0]   pg_frame;
    logic [AW-1:0]   fr_age;
    logic [PW-1:0]   fr_own;
    logic [31:0]     in_vp;
    logic [7:0]      run_nx;
    logic            vic_upd;

    assign pg_use   = pg_rdata[FW];
    assign pg_frame = pg_rdata[FW-1:0];
    assign fr_age   = fr_rdata[FRW-1:PW];
    assign fr_own   = fr_rdata[PW-1:0];
    assign in_vp    = 32'(i_in_beat.virt_address >> OFFW);
    assign run_nx   = pg_use ? 8'd0 : r_run + 8'd1;
    assign vic_upd  = fr_age > r_vage;

    assign o_in_stall = (r_state != S_IDLE);

    pmm_ram #(.WIDTH(PGW), .DEPTH(VIRT_PAGES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    pmm_ram #(.WIDTH(FRW), .DEPTH(TOTAL_FRAMES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    pmm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (beat),
        .o_ready (ofree),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

    always_comb begin
        n_state = r_state;  n_idx   = r_idx;   n_cnt  = r_cnt;   n_run = r_run;
        n_rem   = r_rem;    n_pg    = r_pg;    n_start = r_start; n_i  = r_i;
        n_ok    = r_ok;     n_n     = r_n;     n_vp   = r_vp;    n_off = r_off;
        n_wr    = r_wr;     n_wd    = r_wd;    n_f    = r_f;     n_d   = r_d;
        n_vic   = r_vic;    n_vage  = r_vage;  n_vown = r_vown;  n_spare = r_spare;
        n_res   = r_res;
        pg_we = 1'b0; pg_waddr = '0; pg_wdata = '0; pg_raddr = '0;
        fr_we = 1'b0; fr_waddr = '0; fr_wdata = '0; fr_raddr = '0;
        push  = 1'b0; beat = '0;

        case (r_state)
            S_CLR: begin
                pg_we    = 32'(r_idx) < VIRT_PAGES;
                pg_waddr = r_idx[PW-1:0];
                fr_we    = 32'(r_idx) < TOTAL_FRAMES;
                fr_waddr = r_idx[FW-1:0];
                if (32'(r_idx) == MAXVT - 1) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n   = i_in_beat.page_count;
                    n_wr  = (i_in_beat.opcode == pmm_pkg::OP_WRITE);
                    n_wd  = i_in_beat.write_data;
                    n_off = i_in_beat.virt_address[OFFW-1:0];
                    n_vp  = in_vp[PW-1:0];
                    n_idx = '0;
                    n_res = '0;
                    n_res.last = 1'b1;
                    case (i_in_beat.opcode)
                        pmm_pkg::OP_ALLOC: begin
                            n_res.kind = pmm_pkg::K_ALLOC;
                            n_cnt = '0;
                            if (i_in_beat.page_count == 7'd0 ||
                                32'(i_in_beat.page_count) > VIRT_PAGES) begin
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_CNT_RD;
                            end
                        end
                        pmm_pkg::OP_FREE: begin
                            n_res.kind = pmm_pkg::K_FREE;
                            n_ok  = 1'b1;
                            n_i   = IW'(i_in_beat.start_page);
                            n_rem = i_in_beat.page_count;
                            n_state = S_FREE_RD;
                        end
                        default: begin
                            n_res.kind     = pmm_pkg::K_ACCESS;
                            n_res.is_write = (i_in_beat.opcode == pmm_pkg::OP_WRITE);
                            if (in_vp >= VIRT_PAGES) begin
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_X_RD;
                            end
                        end
                    endcase
                end
            end
            // ---- allocate: count free frames
            S_CNT_RD: begin
                fr_raddr = r_idx[FW-1:0];
                n_state  = S_CNT_CK;
            end
            S_CNT_CK: begin
                if (fr_age == '0) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (32'(r_idx) == TOTAL_FRAMES - 1) begin
                    n_idx = '0;
                    n_run = '0;
                    if (32'(n_cnt) < 32'(r_n)) begin
                        n_state = S_REPLY;
                    end else begin
                        n_state = S_FIT_RD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CNT_RD;
                end
            end
            // ---- allocate: first run of free pages
            S_FIT_RD: begin
                pg_raddr = r_idx[PW-1:0];
                n_state  = S_FIT_CK;
            end
            S_FIT_CK: begin
                n_run = run_nx;
                if (run_nx == {1'b0, r_n}) begin
                    n_start = PW'(32'(r_idx) + 32'd1 - 32'(r_n));
                    n_pg    = PW'(32'(r_idx) + 32'd1 - 32'(r_n));
                    n_rem   = r_n;
                    n_idx   = '0;
                    n_state = S_ASG_RD;
                end else if (32'(r_idx) == VIRT_PAGES - 1) begin
                    n_state = S_REPLY;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FIT_RD;
                end
            end
            // ---- allocate: back each page with the lowest free frame
            S_ASG_RD: begin
                fr_raddr = r_idx[FW-1:0];
                n_state  = S_ASG_CK;
            end
            S_ASG_CK: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_ASG_RD;
                if (fr_age == '0) begin
                    fr_we    = 1'b1;
                    fr_waddr = r_idx[FW-1:0];
                    fr_wdata = {AW'(1), r_pg};
                    pg_we    = 1'b1;
                    pg_waddr = r_pg;
                    pg_wdata = {1'b1, r_idx[FW-1:0]};
                    n_pg     = r_pg + 1'b1;
                    n_rem    = r_rem - 7'd1;
                    if (r_rem == 7'd1) begin
                        n_res.ok         = 1'b1;
                        n_res.page_index = 6'(r_start);
                        n_state          = S_REPLY;
                    end
                end
            end
            // ---- free
            S_FREE_RD: begin
                pg_raddr = r_i[PW-1:0];
                if (r_rem == 7'd0) begin
                    n_res.ok = r_ok;
                    n_state  = S_REPLY;
                end else if (32'(r_i) >= VIRT_PAGES) begin
                    n_ok  = 1'b0;
                    n_i   = r_i + 1'b1;
                    n_rem = r_rem - 7'd1;
                end else begin
                    n_state = S_FREE_CK;
                end
            end
            S_FREE_CK: begin
                if (!pg_use) begin
                    n_ok = 1'b0;
                end else begin
                    pg_we    = 1'b1;
                    pg_waddr = r_i[PW-1:0];
                    pg_wdata = {1'b0, pg_frame};
                    fr_we    = 1'b1;
                    fr_waddr = pg_frame;
                end
                n_i     = r_i + 1'b1;
                n_rem   = r_rem - 7'd1;
                n_state = S_FREE_RD;
            end
            // ---- access: translate
            S_X_RD: begin
                pg_raddr = r_vp;
                n_state  = S_X_CK;
            end
            S_X_CK: begin
                n_idx  = '0;
                n_vage = '0;
                n_vic  = '0;
                if (!pg_use) begin
                    n_state = S_REPLY;
                end else if (32'(pg_frame) < ML) begin
                    n_f     = pg_frame;
                    n_state = S_G_RD;
                end else begin
                    n_d     = pg_frame;
                    n_state = S_M_RD;
                end
            end
            // ---- miss: free memory frame, else oldest victim
            S_M_RD: begin
                fr_raddr = r_idx[FW-1:0];
                n_state  = S_M_CK;
            end
            S_M_CK: begin
                if (fr_age == '0) begin
                    n_f     = r_idx[FW-1:0];
                    n_state = S_LOAD;
                end else begin
                    if (vic_upd) begin
                        n_vage = fr_age;
                        n_vic  = r_idx[FW-1:0];
                        n_vown = fr_own;
                    end
                    n_idx = r_idx + 1'b1;
                    if (32'(r_idx) == ML - 1) begin
                        n_state = S_D_RD;
                    end else begin
                        n_state = S_M_RD;
                    end
                end
            end
            // ---- miss with memory full: free disk frame for the victim
            S_D_RD: begin
                fr_raddr = r_idx[FW-1:0];
                n_state  = S_D_CK;
            end
            S_D_CK: begin
                if (fr_age == '0) begin
                    n_spare = r_idx[FW-1:0];
                    n_state = S_SAVE;
                end else if (32'(r_idx) >= TOTAL_FRAMES - 1) begin
                    n_state = S_REPLY;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_D_RD;
                end
            end
            S_SAVE: begin
                if (ofree) begin
                    push              = 1'b1;
                    beat.kind         = pmm_pkg::K_SAVE;
                    beat.ok           = 1'b1;
                    beat.mem_address  = 16'(32'(r_vic) << OFFW);
                    beat.disk_address = 18'((32'(r_spare) - 32'(ML)) << OFFW);
                    pg_we    = 1'b1;
                    pg_waddr = r_vown;
                    pg_wdata = {1'b1, r_spare};
                    fr_we    = 1'b1;
                    fr_waddr = r_spare;
                    fr_wdata = {AW'(1), r_vown};
                    n_f      = r_vic;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                if (ofree) begin
                    push              = 1'b1;
                    beat.kind         = pmm_pkg::K_LOAD;
                    beat.ok           = 1'b1;
                    beat.mem_address  = 16'(32'(r_f) << OFFW);
                    beat.disk_address = 18'((32'(r_d) - 32'(ML)) << OFFW);
                    fr_we    = 1'b1;
                    fr_waddr = r_d;
                    pg_we    = 1'b1;
                    pg_waddr = r_vp;
                    pg_wdata = {1'b1, r_f};
                    n_idx    = '0;
                    n_state  = S_G_RD;
                end
            end
            // ---- age busy memory frames, used frame becomes most recent
            S_G_RD: begin
                fr_raddr = r_idx[FW-1:0];
                n_state  = S_G_CK;
            end
            S_G_CK: begin
                if (r_idx[FW-1:0] != r_f && fr_age != '0 && fr_age != pmm_pkg::AGE_MAX) begin
                    fr_we    = 1'b1;
                    fr_waddr = r_idx[FW-1:0];
                    fr_wdata = {fr_age + AW'(1), fr_own};
                end
                if (32'(r_idx) == ML - 1) begin
                    n_res.ok          = 1'b1;
                    n_res.mem_address = 16'((32'(r_f) << OFFW) + 32'(r_off));
                    n_res.data_out    = r_wr ? r_wd : 8'd0;
                    n_state           = S_REPLY;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_G_RD;
                end
            end
            S_REPLY: begin
                // an access that hit or was brought in stamps its frame now
                if (r_res.kind == pmm_pkg::K_ACCESS && r_res.ok) begin
                    fr_we    = ofree;
                    fr_waddr = r_f;
                    fr_wdata = {AW'(1), r_vp};
                end
                if (ofree) begin
                    push    = 1'b1;
                    beat    = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_cnt <= n_cnt;   r_run  <= n_run;  r_rem  <= n_rem;  r_pg    <= n_pg;
        r_start <= n_start; r_i  <= n_i;    r_ok   <= n_ok;   r_n     <= n_n;
        r_vp  <= n_vp;    r_off  <= n_off;  r_wr   <= n_wr;   r_wd    <= n_wd;
        r_f   <= n_f;     r_d    <= n_d;    r_vic  <= n_vic;  r_vage  <= n_vage;
        r_vown <= n_vown; r_spare <= n_spare; r_res <= n_res;
    end

    // ---- checks
    a_asg_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASG_CK) |-> (r_rem != 7'd0))
        else $error("frame assignment with no page left");

    a_age_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G_CK) |-> (32'(r_idx) < ML))
        else $error("aging walked past memory frames");

    a_mid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !beat.last) |-> (r_state == S_SAVE || r_state == S_LOAD))
        else $error("non-final beat outside a page move");

    a_used_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (32'(r_f) < ML && 32'(r_d) >= ML))
        else $error("page load frames out of place");

endmodule

/* tb/paged_memory_manager_tb.sv */
// ----------------------------------------------------------------------------
// paged_memory_manager_tb
// Self-checking bench: drives allocate / free / access beats with random gaps
// and output stalls, predicts every result beat, compares in order.
// ----------------------------------------------------------------------------
module paged_memory_manager_tb;

    localparam int unsigned PG_BYTES  = 4096;
    localparam int unsigned N_PAGES   = 64;
    localparam int unsigned N_FRAMES  = 64;
    localparam int unsigned N_MEM     = 16;
    localparam int unsigned IDLE_LIM  = 20000;
    localparam int unsigned N_RANDOM  = 390;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    pmm_pkg::t_in_beat   i_in_beat;
    logic                o_out_valid;
    logic                i_out_stall;
    pmm_pkg::t_out_beat  o_out_beat;

    int unsigned err_cnt;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned idle_cycles;
    int unsigned hits, misses, swaps;

    paged_memory_manager dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    task automatic report(input string what, input pmm_pkg::t_out_beat got,
                          input pmm_pkg::t_out_beat want);
        err_cnt++;
        $display("mismatch @%0t %s: got %p want %p", $realtime, what, got, want);
    endtask

    // Predictor of the page/frame tables plus queue of expected result beats.
    class pager_scoreboard;
        bit                 in_use [N_PAGES];
        int unsigned        pframe [N_PAGES];
        int unsigned        owner  [N_FRAMES];
        int unsigned        age    [N_FRAMES];
        pmm_pkg::t_out_beat pending[$];

        function void push(pmm_pkg::t_kind k, bit ok, int unsigned pidx, int unsigned ma,
                           int unsigned da, bit wr, logic [7:0] d, bit lst);
            pmm_pkg::t_out_beat b;
            b.kind = k; b.ok = ok; b.page_index = pidx[5:0];
            b.mem_address = ma[15:0]; b.disk_address = da[17:0];
            b.is_write = wr; b.data_out = d; b.last = lst;
            pending.push_back(b);
        endfunction

        function int unsigned free_frames();
            int unsigned c;
            c = 0;
            foreach (age[f]) if (age[f] == 0) c++;
            return c;
        endfunction

        function bit allocate(int unsigned n, output int unsigned first);
            int unsigned f;
            bit fits;
            first = 0;
            if (n < 1 || n > N_PAGES || free_frames() < n) return 0;
            for (int unsigned s = 0; s + n <= N_PAGES; s++) begin
                fits = 1;
                for (int unsigned i = s; i < s + n; i++) if (in_use[i]) fits = 0;
                if (!fits) continue;
                f = 0;
                for (int unsigned i = s; i < s + n; i++) begin
                    while (f < N_FRAMES && age[f] != 0) f++;
                    age[f] = 1; owner[f] = i; pframe[i] = f; in_use[i] = 1; f++;
                end
                first = s;
                return 1;
            end
            return 0;
        endfunction

        function void note_input(pmm_pkg::t_in_beat b);
            int unsigned first, vp, off, f, m, d, victim, spare;
            bit ok, wr;
            case (b.opcode)
                pmm_pkg::OP_ALLOC: begin
                    ok = allocate(b.page_count, first);
                    push(pmm_pkg::K_ALLOC, ok, ok ? first : 0, 0, 0, 0, 0, 1);
                end
                pmm_pkg::OP_FREE: begin
                    ok = 1;
                    for (int unsigned i = b.start_page; i < b.start_page + b.page_count; i++)
                    begin
                        if (i >= N_PAGES || !in_use[i]) begin
                            ok = 0;
                            continue;
                        end
                        age[pframe[i]] = 0;
                        in_use[i] = 0;
                    end
                    push(pmm_pkg::K_FREE, ok, 0, 0, 0, 0, 0, 1);
                end
                default: begin
                    wr  = (b.opcode == pmm_pkg::OP_WRITE);
                    vp  = b.virt_address / PG_BYTES;
                    off = b.virt_address % PG_BYTES;
                    if (vp >= N_PAGES || !in_use[vp]) begin
                        push(pmm_pkg::K_ACCESS, 0, 0, 0, 0, wr, 0, 1);
                        return;
                    end
                    f = pframe[vp];
                    if (f >= N_MEM) begin
                        d = f;
                        for (m = 0; m < N_MEM; m++) if (age[m] == 0) break;
                        if (m >= N_MEM) begin
                            victim = 0;
                            for (int unsigned k = 1; k < N_MEM; k++)
                                if (age[k] > age[victim]) victim = k;
                            for (spare = N_MEM; spare < N_FRAMES; spare++)
                                if (age[spare] == 0) break;
                            if (spare >= N_FRAMES) begin
                                push(pmm_pkg::K_ACCESS, 0, 0, 0, 0, wr, 0, 1);
                                return;
                            end
                            push(pmm_pkg::K_SAVE, 1, 0, victim * PG_BYTES,
                                 (spare - N_MEM) * PG_BYTES, 0, 0, 0);
                            swaps++;
                            pframe[owner[victim]] = spare;
                            owner[spare] = owner[victim];
                            age[spare] = 1;
                            m = victim;
                        end
                        push(pmm_pkg::K_LOAD, 1, 0, m * PG_BYTES, (d - N_MEM) * PG_BYTES,
                             0, 0, 0);
                        misses++;
                        age[d] = 0; pframe[vp] = m; owner[m] = vp; f = m;
                    end else begin
                        hits++;
                    end
                    for (int unsigned k = 0; k < N_MEM; k++)
                        if (age[k] != 0 && age[k] < 65535) age[k]++;
                    age[f] = 1;
                    push(pmm_pkg::K_ACCESS, 1, 0, f * PG_BYTES + off, 0, wr,
                         wr ? b.write_data : 8'd0, 1);
                end
            endcase
        endfunction

        task check_result(pmm_pkg::t_out_beat got);
            pmm_pkg::t_out_beat want;
            if (pending.size() == 0) begin
                report("unexpected beat", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind)                 report("kind", got, want);
            if (got.ok != want.ok)                     report("ok", got, want);
            if (got.page_index != want.page_index)     report("page_index", got, want);
            if (got.mem_address != want.mem_address)   report("mem_address", got, want);
            if (got.disk_address != want.disk_address) report("disk_address", got, want);
            if (got.is_write != want.is_write)         report("is_write", got, want);
            if (got.data_out != want.data_out)         report("data_out", got, want);
            if (got.last != want.last)                 report("last", got, want);
        endtask
    endclass

    pager_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap length: mostly none or a short one, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    // Sample both handshakes at the edge; the scoreboard sees beats in edge order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in_beat);
                beats_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_beat);
                beats_out++;
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIM) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIM);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall stretches, with a calm phase of no stall at all.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else if (beats_in < 120 || beats_in > 300)
            i_out_stall <= ($urandom_range(99) < 30) ? 1'b1 :
                           ($urandom_range(99) < 3 ? 1'b1 : 1'b0);
        else
            i_out_stall <= 1'b0;
    end

    // One input beat: raise valid, hold until accepted, then an optional gap.
    task automatic send(input pmm_pkg::t_in_beat b, input bit allow_gap);
        int unsigned g;
        i_in_beat  <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            i_in_beat  <= pmm_pkg::t_in_beat'($urandom());
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic pmm_pkg::t_in_beat mk(pmm_pkg::t_op op, int unsigned n,
                                             int unsigned sp, int unsigned va,
                                             int unsigned wd);
        pmm_pkg::t_in_beat b;
        b = pmm_pkg::t_in_beat'({$urandom(), $urandom()});
        b.opcode = op; b.page_count = n[6:0]; b.start_page = sp[5:0];
        b.virt_address = va[17:0]; b.write_data = wd[7:0];
        return b;
    endfunction

    // Access to a random page at a random offset, now and then a fully random address.
    function automatic pmm_pkg::t_in_beat rand_access();
        int unsigned vp;
        vp = $urandom_range(99) < 85 ? $urandom_range(N_PAGES - 1) : $urandom_range(63);
        return mk($urandom_range(1) ? pmm_pkg::OP_WRITE : pmm_pkg::OP_READ, 0, 0,
                  ($urandom_range(99) < 5) ? $urandom_range(262143)
                                           : vp * PG_BYTES + $urandom_range(PG_BYTES - 1),
                  $urandom_range(255));
    endfunction

    initial begin
        pmm_pkg::t_in_beat b;
        int unsigned r;
        sb = new();
        err_cnt = 0; beats_in = 0; beats_out = 0; idle_cycles = 0;
        hits = 0; misses = 0; swaps = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bad counts, full fill, swapping, free edge cases.
        send(mk(pmm_pkg::OP_ALLOC, 0, 0, 0, 0), 1);            // zero pages
        send(mk(pmm_pkg::OP_ALLOC, 65, 0, 0, 0), 1);           // too many pages
        send(mk(pmm_pkg::OP_ALLOC, 127, 63, 0, 0), 1);
        send(mk(pmm_pkg::OP_READ, 0, 0, 0, 0), 1);             // unallocated access
        send(mk(pmm_pkg::OP_ALLOC, 20, 0, 0, 0), 1);           // spills into disk frames
        send(mk(pmm_pkg::OP_WRITE, 0, 0, 18 * PG_BYTES + 4095, 255), 1);  // miss, memory full
        send(mk(pmm_pkg::OP_READ, 0, 0, 0, 0), 1);             // page 0 was evicted
        send(mk(pmm_pkg::OP_WRITE, 0, 0, 5 * PG_BYTES + 7, 8'hA5), 1);    // hit
        send(mk(pmm_pkg::OP_ALLOC, 44, 0, 0, 0), 1);           // fills all 64 frames
        send(mk(pmm_pkg::OP_READ, 0, 0, 63 * PG_BYTES, 0), 1); // memory and swap full
        send(mk(pmm_pkg::OP_ALLOC, 1, 0, 0, 0), 1);            // no frame left
        send(mk(pmm_pkg::OP_FREE, 0, 10, 0, 0), 1);            // empty free
        send(mk(pmm_pkg::OP_FREE, 4, 62, 0, 0), 1);            // runs off the end
        send(mk(pmm_pkg::OP_READ, 0, 0, 262143, 0), 1);        // last byte of the top page
        send(mk(pmm_pkg::OP_FREE, 3, 30, 0, 0), 1);
        send(mk(pmm_pkg::OP_READ, 0, 0, 45 * PG_BYTES + 1, 0), 1);
        send(mk(pmm_pkg::OP_FREE, 3, 30, 0, 0), 1);            // already free
        send(mk(pmm_pkg::OP_ALLOC, 2, 0, 0, 0), 1);            // first fit into the hole
        send(mk(pmm_pkg::OP_FREE, 64, 0, 0, 0), 1);            // free everything
        send(mk(pmm_pkg::OP_WRITE, 0, 0, 3 * PG_BYTES, 1), 1);

        // Random: allocate / free keep occupancy churning, accesses dominate.
        for (int unsigned i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(99);
            if (r < 14)
                b = mk(pmm_pkg::OP_ALLOC, $urandom_range(99) < 85 ? $urandom_range(8, 1)
                                                                  : $urandom_range(127),
                       0, 0, 0);
            else if (r < 24)
                b = mk(pmm_pkg::OP_FREE, $urandom_range(99) < 85 ? $urandom_range(6, 1)
                                                                 : $urandom_range(127),
                       $urandom_range(63), 0, 0);
            else
                b = rand_access();
            send(b, (i % 100) < 70);
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("%0d input beats, %0d result beats; %0d hits, %0d loads, %0d saves",
                 beats_in, beats_out, hits, misses, swaps);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("FAIL");
        end
        $finish;
    end
endmodule
